[rtl/core/rtpp_pkg.sv]
// rtpp_pkg: types, constants and register codes for the H.264 RTP packetiser.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package rtpp_pkg;

  localparam int NAL_SIZE_BITS = 24;
  localparam int ADDR_W        = 4;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = 2;

  localparam logic [13:0] RTP_HDR      = 14'd12;
  localparam logic [13:0] MIN_MTU      = 14'd64;
  localparam logic [7:0]  NRI_MASK     = 8'h60;
  localparam logic [7:0]  F_MASK       = 8'h80;
  localparam logic [7:0]  KEEP_MASK    = 8'h9F;
  localparam logic [7:0]  STAP_A_TYPE  = 8'd24;
  localparam logic [7:0]  FU_A_TYPE    = 8'd28;
  localparam logic [7:0]  FU_START     = 8'h80;
  localparam logic [7:0]  FU_END       = 8'h40;

  localparam logic [13:0] MTU_RST      = 14'd1400;
  localparam logic [16:0] TS_INC_RST   = 17'd3000;

  typedef enum logic [1:0] {
    REG_MTU     = 2'd0,
    REG_AGG_EN  = 2'd1,
    REG_TS_INC  = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_STAP   = 2'd2,
    MODE_FU     = 2'd3
  } pkt_mode_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_DESC = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0]               data_byte;
    logic                     nal_first;
    logic [NAL_SIZE_BITS-1:0] nal_size;
    logic                     stream_last_nal;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [13:0] packet_length;
    logic        marker;
    logic [31:0] timestamp;
    logic [7:0]  first_byte_final;
  } out_t;

  typedef struct packed {
    logic [13:0] len;
    logic        marker;
    logic [31:0] ts;
    logic [7:0]  fb;
  } desc_t;

  // One command: an optional leading descriptor, up to four bytes, an
  // optional trailing descriptor, emitted in that order.
  typedef struct packed {
    logic            lead_v;
    desc_t           lead;
    logic [3:0]      bmask;
    logic [3:0][7:0] bytes;
    logic            trail_v;
    desc_t           trail;
  } cmd_t;

  typedef struct packed {
    logic [13:0] mtu;
    logic        agg_en;
    logic [16:0] ts_inc;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/core/rtpp_front.sv]
// rtpp_front: packet decision logic; turns each accepted item into at most one command.
// Depends on rtpp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtpp_front (
  input  wire              clk,
  input  wire              rst,
  input  rtpp_pkg::cfg_t   cfg,
  input  wire              accept,
  input  rtpp_pkg::in_t    item,
  output logic             cmd_push,
  output rtpp_pkg::cmd_t   cmd
);
  import rtpp_pkg::*;

  logic [31:0] rtp_time, rtp_time_next;
  logic [13:0] fill, fill_next;
  pkt_mode_t   mode, mode_next;
  logic [7:0]  stap, stap_next;
  logic [7:0]  fu_hdr, fu_hdr_next;
  logic [7:0]  fu_ind, fu_ind_next;
  logic [NAL_SIZE_BITS-1:0] rem, rem_next;
  logic        cur_marker, cur_marker_next;
  logic        cur_last, cur_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rtp_time   <= '0;
      fill       <= '0;
      mode       <= MODE_IDLE;
      stap       <= '0;
      fu_hdr     <= '0;
      fu_ind     <= '0;
      rem        <= '0;
      cur_marker <= 1'b0;
      cur_last   <= 1'b0;
    end else if (accept) begin
      rtp_time   <= rtp_time_next;
      fill       <= fill_next;
      mode       <= mode_next;
      stap       <= stap_next;
      fu_hdr     <= fu_hdr_next;
      fu_ind     <= fu_ind_next;
      rem        <= rem_next;
      cur_marker <= cur_marker_next;
      cur_last   <= cur_last_next;
    end
  end

  always_comb begin
    logic [13:0] m;
    logic [4:0]  ntype;
    logic        vcl;
    logic        agg;
    logic [NAL_SIZE_BITS-1:0] sz;
    logic [NAL_SIZE_BITS+1:0] szw;
    logic [7:0]  b;
    logic [13:0] wf;

    m     = (cfg.mtu < MIN_MTU) ? MIN_MTU : cfg.mtu;
    b     = item.data_byte;
    ntype = b[4:0];
    vcl   = (ntype >= 5'd1) && (ntype <= 5'd5);
    sz    = (item.nal_size == '0) ? {{(NAL_SIZE_BITS-1){1'b0}}, 1'b1} : item.nal_size;
    szw   = {2'b00, sz};
    agg   = cfg.agg_en && (szw + 26'(15) <= 26'(m));
    wf    = fill;

    rtp_time_next   = rtp_time;
    fill_next       = fill;
    mode_next       = mode;
    stap_next       = stap;
    fu_hdr_next     = fu_hdr;
    fu_ind_next     = fu_ind;
    rem_next        = rem;
    cur_marker_next = cur_marker;
    cur_last_next   = cur_last;
    cmd             = '0;

    if (item.nal_first) begin
      // new NAL while the last is unfinished: close what is open
      if (rem != '0) begin
        if (mode != MODE_IDLE) begin
          cmd.lead_v = 1'b1;
          cmd.lead   = '{len: fill + RTP_HDR, marker: 1'b0, ts: rtp_time, fb: stap};
        end
        mode_next = MODE_IDLE;
        fill_next = '0;
      end
      // flush aggregate that cannot take this NAL
      if (mode_next == MODE_STAP &&
          (!agg || 26'(RTP_HDR) + 26'(fill_next) + 26'(2) + szw > 26'(m))) begin
        cmd.lead_v = 1'b1;
        cmd.lead   = '{len: fill_next + RTP_HDR, marker: cur_marker, ts: rtp_time, fb: stap};
        mode_next  = MODE_IDLE;
        fill_next  = '0;
      end
      rtp_time_next   = rtp_time + (vcl ? {15'd0, cfg.ts_inc} : 32'd0);
      cur_marker_next = vcl;
      cur_last_next   = item.stream_last_nal;
      rem_next        = sz - 1'b1;
      if (agg) begin
        if (mode_next != MODE_STAP) begin
          mode_next    = MODE_STAP;
          fill_next    = 14'd1;
          stap_next    = STAP_A_TYPE | (b & NRI_MASK);
          cmd.bmask[0] = 1'b1;
          cmd.bytes[0] = stap_next;
        end else if ((b & NRI_MASK) > (stap & NRI_MASK)) begin
          stap_next = (stap & KEEP_MASK) | (b & NRI_MASK);
        end
        stap_next      = stap_next | (b & F_MASK);
        cmd.bmask[3:1] = 3'b111;
        cmd.bytes[1]   = sz[15:8];
        cmd.bytes[2]   = sz[7:0];
        cmd.bytes[3]   = b;
        fill_next      = fill_next + 14'd3;
        if (rem_next == '0 && item.stream_last_nal) begin
          cmd.trail_v = 1'b1;
          cmd.trail   = '{len: fill_next + RTP_HDR, marker: vcl, ts: rtp_time_next,
                          fb: stap_next};
          mode_next   = MODE_IDLE;
          fill_next   = '0;
        end
      end else if (szw + 26'(RTP_HDR) <= 26'(m)) begin
        mode_next    = MODE_SINGLE;
        stap_next    = b;
        cmd.bmask[3] = 1'b1;
        cmd.bytes[3] = b;
        fill_next    = 14'd1;
        if (rem_next == '0) begin
          cmd.trail_v = 1'b1;
          cmd.trail   = '{len: 14'd1 + RTP_HDR, marker: vcl, ts: rtp_time_next, fb: b};
          mode_next   = MODE_IDLE;
          fill_next   = '0;
        end
      end else begin
        mode_next      = MODE_FU;
        fu_ind_next    = FU_A_TYPE | (b & NRI_MASK);
        fu_hdr_next    = FU_START | {3'd0, ntype};
        stap_next      = fu_ind_next;
        cmd.bmask[1:0] = 2'b11;
        cmd.bytes[0]   = fu_ind_next;
        cmd.bytes[1]   = fu_hdr_next;
        fill_next      = 14'd2;
      end
    end else if (rem != '0 && mode != MODE_IDLE) begin
      rem_next     = rem - 1'b1;
      cmd.bmask[3] = 1'b1;
      cmd.bytes[3] = b;
      case (mode)
        MODE_SINGLE: begin
          fill_next = fill + 14'd1;
          if (rem_next == '0) begin
            cmd.trail_v = 1'b1;
            cmd.trail   = '{len: fill_next + RTP_HDR, marker: cur_marker, ts: rtp_time,
                            fb: stap};
            mode_next   = MODE_IDLE;
            fill_next   = '0;
          end
        end
        MODE_STAP: begin
          fill_next = fill + 14'd1;
          if (rem_next == '0 && cur_last) begin
            cmd.trail_v = 1'b1;
            cmd.trail   = '{len: fill_next + RTP_HDR, marker: cur_marker, ts: rtp_time,
                            fb: stap};
            mode_next   = MODE_IDLE;
            fill_next   = '0;
          end
        end
        default: begin
          // FU-A: a fresh fragment opens with indicator and header
          if (fill == '0) begin
            if (26'(rem) + 26'(2) + 26'(RTP_HDR) <= 26'(m)) fu_hdr_next = fu_hdr | FU_END;
            stap_next      = fu_ind;
            cmd.bmask[1:0] = 2'b11;
            cmd.bytes[0]   = fu_ind;
            cmd.bytes[1]   = fu_hdr_next;
            wf             = 14'd2;
          end
          wf = wf + 14'd1;
          fill_next = wf;
          if (rem_next == '0) begin
            cmd.trail_v = 1'b1;
            cmd.trail   = '{len: wf + RTP_HDR, marker: cur_marker, ts: rtp_time,
                            fb: stap_next};
            mode_next   = MODE_IDLE;
            fill_next   = '0;
          end else if (wf + RTP_HDR >= m) begin
            cmd.trail_v = 1'b1;
            cmd.trail   = '{len: wf + RTP_HDR, marker: 1'b0, ts: rtp_time, fb: stap_next};
            fu_hdr_next = fu_hdr_next & ~FU_START;
            fill_next   = '0;
          end
        end
      endcase
    end

    cmd_push = accept && (cmd.lead_v || cmd.trail_v || (cmd.bmask != '0));
  end

endmodule
`default_nettype wire

[rtl/core/rtpp_cmdq.sv]
// rtpp_cmdq: short command queue between the decision front and the emitter.
// Depends on rtpp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtpp_cmdq (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  rtpp_pkg::cmd_t  wdata,
  input  wire             pop,
  output rtpp_pkg::cmd_t  rdata,
  output logic            full,
  output logic            nonempty
);
  import rtpp_pkg::*;

  cmd_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  assign rdata    = slots[rd_ptr];
  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign nonempty = (count != '0);

endmodule
`default_nettype wire

[rtl/core/rtpp_back.sv]
// rtpp_back: expands queued commands into result items, one per cycle while the receiver pops.
// Depends on rtpp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtpp_back (
  input  wire             clk,
  input  wire             rst,
  input  rtpp_pkg::cmd_t  cmd,
  input  wire             cmd_valid,
  output logic            cmd_pop,
  input  wire             pop,
  output logic            empty,
  output rtpp_pkg::out_t  result
);
  import rtpp_pkg::*;

  logic [5:0] done;
  logic [5:0] mask, remaining, sel;
  logic       out_valid, advance;
  out_t       item;

  assign mask      = {cmd.trail_v, cmd.bmask, cmd.lead_v};
  assign remaining = mask & ~done;
  assign sel       = remaining & (~remaining + 6'd1);
  assign advance   = cmd_valid && (!out_valid || pop);
  assign cmd_pop   = advance && ((remaining & ~sel) == '0);
  assign empty     = !out_valid;

  always_comb begin
    desc_t d;
    d    = sel[0] ? cmd.lead : cmd.trail;
    item = '0;
    if (sel[0] || sel[5]) begin
      item.kind             = KIND_DESC;
      item.packet_length    = d.len;
      item.marker           = d.marker;
      item.timestamp        = d.ts;
      item.first_byte_final = d.fb;
    end else begin
      item.kind = KIND_BYTE;
      for (int i = 0; i < 4; i++) begin
        if (sel[i+1]) item.payload_byte = cmd.bytes[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        done      <= cmd_pop ? '0 : (done | sel);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= item;
  end

endmodule
`default_nettype wire

[rtl/core/h264_rtp_packetizer_top.sv]
// h264_rtp_packetizer_top: H.264 RTP payload former (single NAL, STAP-A, FU-A).
// Depends on rtpp_pkg, rtpp_front, rtpp_cmdq, rtpp_back.
// Path: an accepted item's command is written into the command queue, then into
//   the registered result stage. The emitter gives one result item per cycle while
//   the receiver pops; an item may cause up to 6 results, so full holds off input.
// Reset: synchronous rst clears state, queue and registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module h264_rtp_packetizer_top (
  input  wire                            clk,
  input  wire                            rst,
  // input queue side
  input  wire                            push,
  output logic                           full,
  input  rtpp_pkg::in_t                  in_data,
  // result queue side
  output logic                           empty,
  input  wire                            pop,
  output rtpp_pkg::out_t                 out_data,
  // configuration port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [rtpp_pkg::ADDR_W-1:0]    paddr,
  input  wire  [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rtpp_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_wr;
  logic     accept;
  logic     cmd_push, cmd_pop, q_nonempty;
  cmd_t     cmd_in, cmd_head;

  // registers sit on word addresses; low two address bits are ignored
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mtu    <= MTU_RST;
      cfg.agg_en <= 1'b0;
      cfg.ts_inc <= TS_INC_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MTU:    cfg.mtu    <= pwdata[13:0];
        REG_AGG_EN: cfg.agg_en <= pwdata[0];
        REG_TS_INC: cfg.ts_inc <= pwdata[16:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MTU:    prdata = {18'd0, cfg.mtu};
      REG_AGG_EN: prdata = {31'd0, cfg.agg_en};
      REG_TS_INC: prdata = {15'd0, cfg.ts_inc};
      default:    prdata = '0;
    endcase
  end

  // the front takes an item whenever the command queue has room
  assign accept = push && !full;

  rtpp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .item     (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  rtpp_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .wdata    (cmd_in),
    .pop      (cmd_pop),
    .rdata    (cmd_head),
    .full     (full),
    .nonempty (q_nonempty)
  );

  // the emitter drains commands into a registered result stage
  rtpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_valid (q_nonempty),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (out_data)
  );

endmodule
`default_nettype wire

[rtl/core/rtpp_checker.sv]
// rtpp_checker: port-level assertions for the packetiser, bound to the top.
// Depends on rtpp_pkg and h264_rtp_packetizer_top.
`timescale 1ns / 1ps
`default_nettype none
module rtpp_checker (
  input wire             clk,
  input wire             rst,
  input wire             empty,
  input wire             pop,
  input rtpp_pkg::out_t  out_data,
  input wire             pready
);
  import rtpp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // a fragment cut short by a new NAL may close with no payload at all
  a_desc_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_data.kind == KIND_DESC) |-> (out_data.packet_length >= 14'd12))
    else $error("descriptor shorter than header");

  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_data.kind == KIND_BYTE) |->
      (out_data.packet_length == '0 && out_data.timestamp == '0 && !out_data.marker))
    else $error("payload item carries descriptor fields");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind h264_rtp_packetizer_top rtpp_checker u_rtpp_checker (
  .clk      (clk),
  .rst      (rst),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data),
  .pready   (pready)
);
`default_nettype wire

[tb/tb_h264_rtp_packetizer_top.sv]
// tb_h264_rtp_packetizer_top: self-checking bench for the H.264 RTP packetiser.
// Depends on rtpp_pkg and h264_rtp_packetizer_top; holds its own packet-forming
// predictor and compares every result item against it.
`timescale 1ns / 1ps
module tb_h264_rtp_packetizer_top;
  import rtpp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_t  in_data = '0;
  out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  h264_rtp_packetizer_top DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the packetiser's registers and state.
  // ---------------------------------------------------------------------------
  logic [13:0] cfg_mtu    = MTU_RST;
  logic        cfg_agg    = 1'b0;
  logic [16:0] cfg_ts_inc = TS_INC_RST;

  logic [31:0] ts_now   = '0;
  logic [13:0] fill     = '0;   // payload bytes in the open packet
  pkt_mode_t   mode     = MODE_IDLE;
  logic [7:0]  lead     = '0;   // first payload byte of the open packet
  logic [7:0]  fu_hdr   = '0;
  logic [7:0]  fu_ind   = '0;
  logic [NAL_SIZE_BITS-1:0] nal_left = '0;
  logic        cur_mark = 1'b0;
  logic        cur_last = 1'b0;

  out_t expected_q[$];

  int errors = 0;
  int n_in = 0, n_out = 0, n_desc = 0, n_fu = 0, n_stap = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_rx = 1'b0;
  bit cfg_busy = 1'b0;

  function automatic void emit_payload(logic [7:0] b);
    out_t r;
    r = '0;
    r.kind = KIND_BYTE;
    r.payload_byte = b;
    expected_q.push_back(r);
    fill = fill + 14'd1;
  endfunction

  function automatic void close_packet(logic mk);
    out_t r;
    r = '0;
    r.kind = KIND_DESC;
    r.packet_length = fill + RTP_HDR;
    r.marker = mk;
    r.timestamp = ts_now;
    r.first_byte_final = lead;
    expected_q.push_back(r);
    fill = '0;
    mode = MODE_IDLE;
  endfunction

  // Works out the result items caused by one accepted NAL byte.
  function automatic void packetise_byte(in_t it);
    longint m, sz;
    logic [7:0] b, typ;
    logic vcl, agg;
    b = it.data_byte;
    m = (cfg_mtu < MIN_MTU) ? longint'(MIN_MTU) : longint'(cfg_mtu);
    if (it.nal_first) begin
      typ = b & 8'h1F;
      vcl = (typ >= 8'd1 && typ <= 8'd5);
      // new NAL before the old one ended: cut the open packet short
      if (nal_left != 0) begin
        if (mode != MODE_IDLE) close_packet(1'b0);
        mode = MODE_IDLE;
        fill = '0;
        nal_left = '0;
      end
      sz = (it.nal_size == 0) ? 1 : longint'(it.nal_size);
      agg = cfg_agg && (sz + 15 <= m);
      if (mode == MODE_STAP && (!agg || 12 + longint'(fill) + 2 + sz > m))
        close_packet(cur_mark);
      if (vcl) ts_now = ts_now + 32'(cfg_ts_inc);
      cur_mark = vcl;
      cur_last = it.stream_last_nal;
      nal_left = NAL_SIZE_BITS'(sz);
      if (agg) begin
        if (mode != MODE_STAP) begin
          mode = MODE_STAP;
          fill = '0;
          lead = STAP_A_TYPE | (b & NRI_MASK);
          emit_payload(lead);
          n_stap++;
        end else if ((b & NRI_MASK) > (lead & NRI_MASK)) begin
          lead = (lead & KEEP_MASK) | (b & NRI_MASK);
        end
        lead = lead | (b & F_MASK);
        emit_payload(8'(sz >> 8));
        emit_payload(8'(sz));
        emit_payload(b);
        nal_left = nal_left - 1'b1;
        if (nal_left == 0 && cur_last) close_packet(cur_mark);
      end else if (sz + 12 <= m) begin
        mode = MODE_SINGLE;
        fill = '0;
        lead = b;
        emit_payload(b);
        nal_left = nal_left - 1'b1;
        if (nal_left == 0) close_packet(cur_mark);
      end else begin
        mode = MODE_FU;
        fill = '0;
        fu_ind = FU_A_TYPE | (b & NRI_MASK);
        fu_hdr = FU_START | typ;
        lead = fu_ind;
        nal_left = nal_left - 1'b1;
        emit_payload(fu_ind);
        emit_payload(fu_hdr);
        n_fu++;
      end
      return;
    end
    // stray byte outside any NAL
    if (nal_left == 0 || mode == MODE_IDLE) return;
    case (mode)
      MODE_SINGLE: begin
        emit_payload(b);
        nal_left = nal_left - 1'b1;
        if (nal_left == 0) close_packet(cur_mark);
      end
      MODE_STAP: begin
        emit_payload(b);
        nal_left = nal_left - 1'b1;
        if (nal_left == 0 && cur_last) close_packet(cur_mark);
      end
      default: begin
        // FU-A: each fresh fragment starts with indicator and header
        if (fill == 0) begin
          if (longint'(nal_left) + 2 + 12 <= m) fu_hdr = fu_hdr | FU_END;
          lead = fu_ind;
          emit_payload(fu_ind);
          emit_payload(fu_hdr);
        end
        emit_payload(b);
        nal_left = nal_left - 1'b1;
        if (nal_left == 0) begin
          close_packet(cur_mark);
        end else if (longint'(fill) + 12 >= m) begin
          close_packet(1'b0);
          mode = MODE_FU;
          fu_hdr = fu_hdr & ~FU_START;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus a long hold-off when asked.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst || hold_rx) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    out_t e;
    if (!rst && pop && !empty) begin
      n_out++;
      if (out_data.kind == KIND_DESC) n_desc++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item %p", $time, out_data);
      end else begin
        e = expected_q.pop_front();
        if (out_data.kind !== e.kind || out_data.payload_byte !== e.payload_byte ||
            out_data.packet_length !== e.packet_length ||
            out_data.marker !== e.marker || out_data.timestamp !== e.timestamp ||
            out_data.first_byte_final !== e.first_byte_final) begin
          errors++;
          $display("%0t: mismatch: expected %p, got %p", $time, e, out_data);
        end
      end
    end
  end

  // Watchdog: cycles with nothing accepted on either side
  int stuck = 0;
  always @(posedge clk) begin
    if (rst || cfg_busy || (push && !full) || (pop && !empty)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= 20000) begin
      $display("FAIL h264_rtp_packetizer_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    packetise_byte(it);
    n_in++;
  endtask

  // One NAL: header byte, then body bytes; cut below size ends it early.
  task automatic send_nal(logic [7:0] hdr, int unsigned size, bit last,
                          int unsigned cut = 0);
    in_t it;
    int unsigned n;
    it.data_byte = hdr;
    it.nal_first = 1'b1;
    it.nal_size = NAL_SIZE_BITS'(size);
    it.stream_last_nal = last;
    send_item(it);
    n = (cut != 0 && cut < size) ? cut : size;
    for (int unsigned i = 1; i < n; i++) begin
      it.data_byte = 8'($urandom);
      it.nal_first = 1'b0;
      it.nal_size = NAL_SIZE_BITS'($urandom);  // ignored off the header byte
      it.stream_last_nal = 1'($urandom);
      send_item(it);
    end
  endtask

  // Sender pause: wait for every expected item, then the pipeline tail.
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    cfg_busy = 1'b1;
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MTU:    cfg_mtu = val[13:0];
      REG_AGG_EN: cfg_agg = val[0];
      REG_TS_INC: cfg_ts_inc = val[16:0];
      default: ;
    endcase
    // read it back
    @(negedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[16:0] !== ((idx == REG_MTU) ? 17'(cfg_mtu) :
                          (idx == REG_AGG_EN) ? 17'(cfg_agg) : cfg_ts_inc)) begin
      errors++;
      $display("%0t: register %0d readback: expected %h, got %h",
               $time, idx, val, prdata);
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
    cfg_busy = 1'b0;
  endtask

  task automatic set_config(logic [13:0] m, logic a, logic [16:0] inc);
    reg_write(REG_MTU, 32'(m));
    reg_write(REG_AGG_EN, 32'(a));
    reg_write(REG_TS_INC, 32'(inc));
  endtask

  function automatic logic [7:0] rand_hdr();
    // bias towards picture NAL types so the timestamp moves
    logic [7:0] h;
    h = 8'($urandom);
    if ($urandom_range(1)) h[4:0] = 5'($urandom_range(1, 5));
    return h;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_single_nal();
    set_config(14'd1400, 1'b0, 17'd3000);
    send_nal(8'h65, 3, 0);          // picture NAL, marker set
    send_nal(8'hE7, 1, 0);          // F set, non-picture
    send_nal(8'h01, 0, 1);          // zero size acts as one byte
    drain();
  endtask

  task automatic test_stap_a();
    // small MTU (acts as 64): merge NRI and F, then a NAL too big to
    // aggregate flushes the aggregate and goes out as two FU-A fragments
    set_config(14'd0, 1'b1, 17'd90000);
    send_nal(8'h27, 2, 0);
    send_nal(8'hC8, 1, 0);          // higher NRI and F merge into the header
    send_nal(8'h06, 41, 0);         // header included, still fits the MTU
    send_nal(8'h65, 55, 1);
    drain();
  endtask

  task automatic test_fu_a();
    set_config(14'd16383, 1'b0, 17'h1FFFF);
    send_nal(8'h25, 2, 0);
    drain();
    set_config(14'd64, 1'b0, 17'h1FFFF);
    // NAL left unfinished by a new header; the huge size exercises every bit
    send_nal(8'h1F, 24'hFFFFFF, 0, 4);
    send_nal(8'h00, 2, 1);
    begin
      in_t it;
      it = '{data_byte: 8'hFF, nal_first: 1'b0, nal_size: '1, stream_last_nal: 1'b1};
      send_item(it);                // stray byte, ignored
    end
    drain();
  endtask

  // Random NAL streams under one idling mix.
  task automatic test_random(int idle_pct, int stall_pct, int bytes);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    set_config(14'($urandom_range(40, 200)), 1'($urandom), 17'($urandom_range(0, 90000)));
    start = n_in;
    while (n_in - start < bytes) begin
      int unsigned sz;
      int r;
      r = $urandom_range(99);
      sz = (r < 80) ? $urandom_range(1, 6) : $urandom_range(7, 60);
      if (r < 10)      send_nal(rand_hdr(), sz, 1'($urandom), $urandom_range(1, sz));
      else if (r < 14) send_nal(rand_hdr(), $urandom, 0, $urandom_range(1, 6));
      else             send_nal(rand_hdr(), sz, ($urandom_range(9) == 0));
      if ($urandom_range(19) == 0) begin
        in_t it;
        it = in_t'({$urandom, $urandom});
        it.nal_first = 1'b0;
        send_item(it);
      end
    end
    drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(14'd64, 1'b1, 17'd1);
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end
      begin
        for (int i = 0; i < 4; i++) send_nal(rand_hdr(), $urandom_range(1, 3), 0);
        send_nal(rand_hdr(), 3, 1);
      end
    join
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_nal();
    test_stap_a();
    test_fu_a();
    test_backpressure();
    test_random(0, 0, 5);
    test_random(46, 0, 5);
    test_random(0, 46, 5);
    test_random(11, 11, 5);

    if (expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected items never arrived", $time, expected_q.size());
    end
    $display("Covered %0d input items, %0d result items, %0d packets (%0d STAP-A, %0d FU-A NALs)",
             n_in, n_out, n_desc, n_stap, n_fu);
    $display("with MTU extremes, aggregation on and off and receiver hold-off; %0d errors",
             errors);
    if (errors == 0) $display("PASS h264_rtp_packetizer_top");
    else $display("FAIL h264_rtp_packetizer_top");
    $finish;
  end

endmodule

[sim.f]
rtl/core/rtpp_pkg.sv
rtl/core/rtpp_front.sv
rtl/core/rtpp_cmdq.sv
rtl/core/rtpp_back.sv
rtl/core/h264_rtp_packetizer_top.sv
rtl/core/rtpp_checker.sv
tb/tb_h264_rtp_packetizer_top.sv
